>>> hw/rtl/afre_pkg.sv
// ----------------------------------------------------------------------------
// afre_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package afre_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PLAY  = 3'd1;
  localparam logic [2:0] OP_PAUSE = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_BASE  = 3'd4;

  localparam logic [15:0] UNITY   = 16'd32768;
  localparam logic [3:0]  MAX_RES = 4'd8;

  typedef struct packed {
    logic ld_in;
    logic dec;
    logic idx_inc;
    logic remove;
    logic flags_ld;
    logic mix_wr;
    logic base_wr;
    logic div_start;
    logic append;
    logic mul_ld;
    logic adv;
    logic tot_ld;
    logic emit;
    logic n_inc;
  } afre_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_base;
    logic is_set;
    logic is_pause;
    logic op_bad;
    logic dur_zero;
    logic idx_lt;
    logic match;
    logic full;
    logic same;
    logic div_done;
    logic n_lt;
    logic out_empty;
  } afre_sts_t;

endpackage

>>> hw/rtl/audio_fade_ramp_engine.sv
// ----------------------------------------------------------------------------
// audio_fade_ramp_engine
// per-track linear volume fader table with saturated Q1.15 results
// ----------------------------------------------------------------------------
// input stream: s_tuser carries the operation (tick, play, pause, set volume,
// set base volume), s_tdata the track, restart flag, volume, duration and
// elapsed time. output stream: one transaction per result, m_tlast on the
// final result of a command. a tick gives one result per fader (at most 8),
// other commands at most one, unknown operations or tracks none.
// one command at a time: s_tready is high only while idle.
// a play, pause or set command walks the fader table to cancel the track's
// fader, then either applies the volume or, unless the table is full, runs
// the bit-serial rate divider before appending the fader.
// reset sets every mix level to 0, every base level to unity and empties
// the fader table. a stalled receiver holds the result register; the
// sequencer waits and takes no new command until every result is taken.
// ----------------------------------------------------------------------------
module audio_fade_ramp_engine #(
  parameter int TRACKS = 16,
  parameter int FADERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // track, restart, volume, duration, delta_time
  input  logic [2:0]  s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // track_res, volume_valid, total_volume, stop,
                                // restart_cmd, resume_cmd, table_full
  output logic        m_tlast
);
  import afre_pkg::*;

  afre_cmd_t cmd;
  afre_sts_t sts;

  afre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afre_dp #(
    .TRACKS (TRACKS),
    .FADERS (FADERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (s_tuser),
    .in_data  (s_tdata[52:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );
endmodule

>>> hw/rtl/afre_div.sv
// ----------------------------------------------------------------------------
// afre_div
// restoring divider, one quotient bit per cycle, signed result
// ----------------------------------------------------------------------------
module afre_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic        neg,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import afre_pkg::*;

  logic [32:0] dvd;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic        sign;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  assign rem_sh  = {rem[15:0], dvd[32]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign quotient = sign ? (32'd0 - dvd[31:0]) : dvd[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        dvd  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        sign <= neg;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dsr}) begin
          rem <= rem_sub;
          dvd <= {dvd[31:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hw/rtl/afre_dp.sv
// ----------------------------------------------------------------------------
// afre_dp
// track levels, fader table, ramp arithmetic and output register
// ----------------------------------------------------------------------------
module afre_dp #(
  parameter int TRACKS = 16,
  parameter int FADERS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  afre_pkg::afre_cmd_t cmd,
  output afre_pkg::afre_sts_t sts,
  input  logic [2:0]         in_op,
  input  logic [52:0]        in_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic               m_tlast
);
  import afre_pkg::*;

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int IW = (FADERS > 1) ? $clog2(FADERS) : 1;
  localparam int FW = $clog2(FADERS + 1);

  logic [31:0] mix  [TRACKS];
  logic [15:0] base [TRACKS];
  logic [3:0]  f_trk   [FADERS];
  logic [15:0] f_tgt   [FADERS];
  logic [31:0] f_rate  [FADERS];
  logic        f_pause [FADERS];
  logic [FW-1:0] cnt;
  logic [FW-1:0] idx;

  logic [2:0]  op;
  logic [3:0]  trk;
  logic        rbit;
  logic [15:0] vol;
  logic [15:0] dur;
  logic [15:0] dt;

  logic [3:0]  res_trk;
  logic        res_vv, res_stop, res_rst, res_rsm, res_full;
  logic [3:0]  n;
  logic [3:0]  lim;
  logic signed [48:0] prod;
  logic [47:0] tot;

  logic [IW-1:0] ix;
  logic [TW-1:0] ti;
  logic [TW-1:0] fi;
  logic [TW-1:0] ri;
  logic [15:0] cmd_tgt;
  logic [33:0] diff;
  logic [32:0] mag;
  logic        div_done;
  logic [31:0] div_q;
  logic signed [49:0] nm;
  logic signed [49:0] tgt50;
  logic        fin;
  logic        rate_pos, rate_zero;
  logic [15:0] tot_sat;

  assign ix = idx[IW-1:0];
  assign ti = TW'(trk);
  assign fi = TW'(f_trk[ix]);
  assign ri = TW'(res_trk);

  always_comb begin
    case (op)
      OP_PLAY:  cmd_tgt = UNITY;
      OP_PAUSE: cmd_tgt = 16'd0;
      default:  cmd_tgt = vol;
    endcase
  end

  assign diff = {3'b0, cmd_tgt, 15'b0} - {2'b0, mix[ti]};
  assign mag  = diff[33] ? 33'(34'd0 - diff) : diff[32:0];

  afre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .neg      (diff[33]),
    .divisor  (dur),
    .done     (div_done),
    .quotient (div_q)
  );

  assign nm        = $signed({18'b0, mix[fi]}) + $signed({prod[48], prod});
  assign tgt50     = $signed({19'b0, f_tgt[ix], 15'b0});
  assign rate_zero = (f_rate[ix] == 32'd0);
  assign rate_pos  = !f_rate[ix][31] && !rate_zero;
  assign fin       = rate_zero || (rate_pos && (nm > tgt50))
                     || (f_rate[ix][31] && (nm < tgt50));
  assign tot_sat   = (tot[47:30] > 18'd65535) ? 16'hFFFF : tot[45:30];

  always_comb begin
    sts.is_tick   = (op == OP_TICK);
    sts.is_base   = (op == OP_BASE);
    sts.is_set    = (op == OP_SET);
    sts.is_pause  = (op == OP_PAUSE);
    sts.op_bad    = (op > OP_BASE) || (32'(trk) >= TRACKS);
    sts.dur_zero  = (dur == 16'd0);
    sts.idx_lt    = (idx < cnt);
    sts.match     = (f_trk[ix] == trk);
    sts.full      = (32'(cnt) >= FADERS);
    sts.same      = ({1'b0, vol, 15'b0} == {1'b0, mix[ti]});
    sts.div_done  = div_done;
    sts.n_lt      = (n < MAX_RES);
    sts.out_empty = !m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TRACKS; k++) begin
        mix[k]  <= 32'd0;
        base[k] <= UNITY;
      end
      cnt      <= '0;
      idx      <= '0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.ld_in) begin
        op   <= in_op;
        trk  <= in_data[3:0];
        rbit <= in_data[4];
        vol  <= in_data[20:5];
        dur  <= in_data[36:21];
        dt   <= in_data[52:37];
      end
      if (cmd.dec) begin
        idx      <= '0;
        n        <= '0;
        lim      <= (32'(cnt) > 8) ? MAX_RES : 4'(cnt);
        res_trk  <= trk;
        res_vv   <= 1'b1;
        res_stop <= 1'b0;
        res_rst  <= 1'b0;
        res_rsm  <= 1'b0;
        res_full <= 1'b0;
      end
      if (cmd.base_wr) base[ti] <= vol;
      if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.flags_ld) begin
        res_rst  <= (op == OP_PLAY) && rbit;
        res_rsm  <= (op == OP_PLAY) && !rbit;
        res_full <= (dur != 16'd0) && (32'(cnt) >= FADERS);
        res_stop <= (op == OP_PAUSE) && (dur == 16'd0);
        res_vv   <= (op != OP_PAUSE) && (dur == 16'd0);
      end
      if (cmd.mix_wr) mix[ti] <= {1'b0, cmd_tgt, 15'b0};
      if (cmd.mul_ld) prod <= $signed(f_rate[ix]) * $signed({1'b0, dt});
      if (cmd.adv) begin
        res_trk  <= f_trk[ix];
        res_stop <= fin && f_pause[ix];
        mix[fi]  <= fin ? {f_tgt[ix], 15'b0} : nm[31:0];
        if (!fin) idx <= idx + 1'b1;
      end
      if (cmd.remove || (cmd.adv && fin)) begin
        for (int j = 0; j < FADERS - 1; j++) begin
          if (FW'(j) >= idx) begin
            f_trk[j]   <= f_trk[j + 1];
            f_tgt[j]   <= f_tgt[j + 1];
            f_rate[j]  <= f_rate[j + 1];
            f_pause[j] <= f_pause[j + 1];
          end
        end
        cnt <= cnt - 1'b1;
      end
      if (cmd.append) begin
        f_trk[cnt[IW-1:0]]   <= trk;
        f_tgt[cnt[IW-1:0]]   <= cmd_tgt;
        f_rate[cnt[IW-1:0]]  <= div_q;
        f_pause[cnt[IW-1:0]] <= (op == OP_PAUSE);
        cnt <= cnt + 1'b1;
      end
      if (cmd.tot_ld) tot <= base[ri] * mix[ri];
      if (cmd.n_inc) n <= n + 4'd1;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'b0, res_full, res_rsm, res_rst, res_stop,
                     (res_vv ? tot_sat : 16'd0), res_vv, res_trk};
        m_tlast  <= (op == OP_TICK) ? (n == lim - 4'd1) : 1'b1;
      end
    end
  end
endmodule

>>> hw/rtl/afre_ctrl.sv
// ----------------------------------------------------------------------------
// afre_ctrl
// command sequencer: cancel walk, divide, tick walk and result handoff
// ----------------------------------------------------------------------------
module afre_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  afre_pkg::afre_sts_t sts,
  output afre_pkg::afre_cmd_t cmd
);
  import afre_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DECODE = 10'b0000000010,
    ST_CANCEL = 10'b0000000100,
    ST_ACT    = 10'b0000001000,
    ST_DIV    = 10'b0000010000,
    ST_MULT   = 10'b0000100000,
    ST_ADD    = 10'b0001000000,
    ST_TOT    = 10'b0010000000,
    ST_EMIT   = 10'b0100000000,
    ST_WAIT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.ld_in  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.dec = 1'b1;
        if (sts.is_tick) begin
          state_next = ST_MULT;
        end else if (sts.op_bad) begin
          state_next = ST_IDLE;
        end else if (sts.is_base) begin
          cmd.base_wr = 1'b1;
          state_next  = ST_TOT;
        end else begin
          state_next = ST_CANCEL;
        end
      end
      ST_CANCEL: begin
        if (!sts.idx_lt) begin
          state_next = ST_ACT;
        end else if (sts.match) begin
          cmd.remove = 1'b1;
          state_next = ST_ACT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_ACT: begin
        cmd.flags_ld = 1'b1;
        if (sts.is_set && sts.same) begin
          state_next = ST_IDLE;
        end else if (!sts.dur_zero) begin
          if (sts.full) begin
            state_next = ST_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end else begin
          cmd.mix_wr = 1'b1;
          if (sts.is_pause) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_TOT;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.append = 1'b1;
          cmd.emit   = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_MULT: begin
        if (sts.idx_lt) begin
          cmd.mul_ld = 1'b1;
          state_next = ST_ADD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ADD: begin
        cmd.adv    = 1'b1;
        state_next = ST_TOT;
      end
      ST_TOT: begin
        cmd.tot_ld = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.is_tick || sts.n_lt) begin
          cmd.emit   = 1'b1;
          state_next = ST_WAIT;
        end else begin
          state_next = ST_MULT;
        end
      end
      ST_WAIT: begin
        if (sts.out_empty) begin
          if (sts.is_tick) begin
            cmd.n_inc  = 1'b1;
            state_next = ST_MULT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end
endmodule
